// File: rtl/usg_pkg.sv
// ----------------------------------------------------------------------------
// usg_pkg
// Shared types, constants and the arctangent table for the uv-sphere point
// generator.
// ----------------------------------------------------------------------------
package usg_pkg;

    localparam int MAX_DIVISIONS_DEF = 256;
    localparam int CORDIC_STAGES_DEF = 16;

    // numerator width of the phase dividers (index above a 32-bit fraction for rho, 33-bit for theta)
    localparam int DIV_W = 42;
    localparam int REM_W = 10;

    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic [31:0] PHASE_QUARTER = 32'h4000_0000;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] quot;
    } div_beat_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [1:0]         quad;
    } rot_beat_t;

    typedef struct packed {
        logic        vld;
        logic        pv;
        logic        qv;
        logic [16:0] k1;
        logic [16:0] k2;
    } side_beat_t;

    // atan(2^-k) in phase units, 2^32 to the turn
    function automatic logic signed [31:0] atan_turn(input int k);
        logic signed [31:0] v;
        v = '0;
        unique case (k)
            0:  v = 32'sd536870912;
            1:  v = 32'sd316933406;
            2:  v = 32'sd167458907;
            3:  v = 32'sd85004756;
            4:  v = 32'sd42667331;
            5:  v = 32'sd21354465;
            6:  v = 32'sd10679838;
            7:  v = 32'sd5340245;
            8:  v = 32'sd2670163;
            9:  v = 32'sd1335087;
            10: v = 32'sd667544;
            11: v = 32'sd333772;
            12: v = 32'sd166886;
            13: v = 32'sd83443;
            14: v = 32'sd41722;
            15: v = 32'sd20861;
            16: v = 32'sd10430;
            17: v = 32'sd5215;
            18: v = 32'sd2608;
            19: v = 32'sd1304;
            20: v = 32'sd652;
            21: v = 32'sd326;
            22: v = 32'sd163;
            23: v = 32'sd81;
            24: v = 32'sd41;
            25: v = 32'sd20;
            26: v = 32'sd10;
            27: v = 32'sd5;
            28: v = 32'sd3;
            29: v = 32'sd1;
            30: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/usg_div_cell.sv
// ----------------------------------------------------------------------------
// usg_div_cell
// One restoring division step: brings down a numerator bit, yields one
// quotient bit.
// ----------------------------------------------------------------------------
module usg_div_cell (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [usg_pkg::REM_W-1:0]  divisor,
    input  usg_pkg::div_beat_t         d_in,
    output usg_pkg::div_beat_t         d_out
);
    import usg_pkg::*;

    div_beat_t           beat_reg;
    div_beat_t           beat_next;
    logic [REM_W:0]      trial;
    logic                ge;

    always_comb begin
        trial = {d_in.rem, d_in.num[DIV_W-1]};
        ge    = (trial >= {1'b0, divisor});
        beat_next.rem  = ge ? REM_W'(trial - {1'b0, divisor}) : trial[REM_W-1:0];
        beat_next.num  = {d_in.num[DIV_W-2:0], 1'b0};
        beat_next.quot = {d_in.quot[DIV_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            beat_reg <= beat_next;
        end
    end

    assign d_out = beat_reg;

endmodule

// File: rtl/usg_cordic_cell.sv
// ----------------------------------------------------------------------------
// usg_cordic_cell
// One rotation-mode cordic micro-rotation with a fixed shift.
// ----------------------------------------------------------------------------
module usg_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic                aclk,
    input  logic                en,
    input  usg_pkg::rot_beat_t  r_in,
    output usg_pkg::rot_beat_t  r_out
);
    import usg_pkg::*;

    localparam logic signed [31:0] ANGLE = atan_turn(SHIFT);

    rot_beat_t          beat_reg;
    rot_beat_t          beat_next;
    logic signed [31:0] dx;
    logic signed [31:0] dy;

    always_comb begin
        dx = r_in.y >>> SHIFT;
        dy = r_in.x >>> SHIFT;
        beat_next.quad = r_in.quad;
        if (!r_in.z[31]) begin
            beat_next.x = r_in.x - dx;
            beat_next.y = r_in.y + dy;
            beat_next.z = r_in.z - ANGLE;
        end else begin
            beat_next.x = r_in.x + dx;
            beat_next.y = r_in.y - dy;
            beat_next.z = r_in.z + ANGLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            beat_reg <= beat_next;
        end
    end

    assign r_out = beat_reg;

endmodule

// File: rtl/uv_sphere_point_generator.sv
// ----------------------------------------------------------------------------
// uv_sphere_point_generator
// Unit-sphere vertex and quad triangle indices for one grid point per beat.
//
//   channel  direction  beat contents
//   s_       in         stack_index, sector_index
//   m_       out        point_valid, pos_x/y/z, quad_valid, tri_a0..tri_b2
//   apb      in/out     stack_count (0x0), sector_count (0x4)
//
// One beat per cycle while m_ is not stalled; the path runs through the 42-cell
// phase divider chain, the cordic chain, the multiply stage and the output
// register. A stall on m_ freezes the whole chain in place.
// Reset clears the beat valids and loads the counts 16 and 32.
// ----------------------------------------------------------------------------
module uv_sphere_point_generator #(
    parameter int MAX_DIVISIONS = usg_pkg::MAX_DIVISIONS_DEF,
    parameter int CORDIC_STAGES = usg_pkg::CORDIC_STAGES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [8:0]         s_stack_index,
    input  logic [8:0]         s_sector_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_point_valid,
    output logic signed [15:0] m_pos_x,
    output logic signed [15:0] m_pos_y,
    output logic signed [15:0] m_pos_z,
    output logic               m_quad_valid,
    output logic [16:0]        m_tri_a0,
    output logic [16:0]        m_tri_a1,
    output logic [16:0]        m_tri_a2,
    output logic [16:0]        m_tri_b0,
    output logic [16:0]        m_tri_b1,
    output logic [16:0]        m_tri_b2
);
    import usg_pkg::*;

    localparam int SIDE_N = DIV_W + CORDIC_STAGES + 1;

    // configuration
    logic [8:0] stack_count_reg;
    logic [8:0] sector_count_reg;
    logic [8:0] stack_eff;
    logic [8:0] sector_eff;

    function automatic logic [8:0] eff_count(input logic [8:0] v);
        logic [8:0] r;
        r = v;
        if (v == 9'd0) begin
            r = 9'd1;
        end else if ({23'd0, v} > 32'(MAX_DIVISIONS)) begin
            r = 9'(MAX_DIVISIONS);
        end
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stack_count_reg  <= 9'd16;
            sector_count_reg <= 9'd32;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) begin
                sector_count_reg <= pwdata[8:0];
            end else begin
                stack_count_reg <= pwdata[8:0];
            end
        end
    end

    assign prdata     = paddr[2] ? {23'd0, sector_count_reg} : {23'd0, stack_count_reg};
    assign pready     = 1'b1;
    assign stack_eff  = eff_count(stack_count_reg);
    assign sector_eff = eff_count(sector_count_reg);

    // handshake: the whole chain advances together
    logic m_valid_reg;
    logic adv;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // phase dividers
    div_beat_t rho_div  [0:DIV_W];
    div_beat_t th_div   [0:DIV_W];
    logic [REM_W-1:0] rho_dvs;
    logic [REM_W-1:0] th_dvs;

    assign rho_dvs = {stack_eff, 1'b0};
    assign th_dvs  = {sector_eff, 1'b0};

    always_comb begin
        rho_div[0].rem  = '0;
        rho_div[0].num  = {1'b0, s_stack_index, 23'd0, stack_eff};
        rho_div[0].quot = '0;
        th_div[0].rem   = '0;
        th_div[0].num   = {s_sector_index, 24'd0, sector_eff};
        th_div[0].quot  = '0;
    end

    for (genvar d = 0; d < DIV_W; d++) begin : g_div
        usg_div_cell u_rho (
            .aclk    (aclk),
            .en      (adv),
            .divisor (rho_dvs),
            .d_in    (rho_div[d]),
            .d_out   (rho_div[d+1])
        );
        usg_div_cell u_th (
            .aclk    (aclk),
            .en      (adv),
            .divisor (th_dvs),
            .d_in    (th_div[d]),
            .d_out   (th_div[d+1])
        );
    end

    // cordic chains
    rot_beat_t  rho_rot [0:CORDIC_STAGES];
    rot_beat_t  th_rot  [0:CORDIC_STAGES];
    logic [31:0] rho_ph;
    logic [31:0] th_ph;

    always_comb begin
        rho_ph = PHASE_QUARTER - rho_div[DIV_W].quot[31:0];
        th_ph  = th_div[DIV_W].quot[31:0];
        rho_rot[0].x    = CORDIC_GAIN;
        rho_rot[0].y    = '0;
        rho_rot[0].z    = {2'b00, rho_ph[29:0]};
        rho_rot[0].quad = rho_ph[31:30];
        th_rot[0].x     = CORDIC_GAIN;
        th_rot[0].y     = '0;
        th_rot[0].z     = {2'b00, th_ph[29:0]};
        th_rot[0].quad  = th_ph[31:30];
    end

    for (genvar c = 0; c < CORDIC_STAGES; c++) begin : g_rot
        usg_cordic_cell #(.SHIFT(c)) u_rho (
            .aclk  (aclk),
            .en    (adv),
            .r_in  (rho_rot[c]),
            .r_out (rho_rot[c+1])
        );
        usg_cordic_cell #(.SHIFT(c)) u_th (
            .aclk  (aclk),
            .en    (adv),
            .r_in  (th_rot[c]),
            .r_out (th_rot[c+1])
        );
    end

    // quadrant fold
    function automatic logic signed [63:0] fold_cs(input rot_beat_t r);
        logic signed [31:0] c;
        logic signed [31:0] s;
        c = r.x;
        s = r.y;
        unique case (r.quad)
            2'd0: begin c = r.x;  s = r.y;  end
            2'd1: begin c = -r.y; s = r.x;  end
            2'd2: begin c = -r.x; s = -r.y; end
            default: begin c = r.y; s = -r.x; end
        endcase
        return {c, s};
    endfunction

    logic signed [63:0] rho_cs;
    logic signed [63:0] th_cs;
    logic signed [31:0] cos_rho;
    logic signed [31:0] sin_rho;
    logic signed [31:0] cos_th;
    logic signed [31:0] sin_th;

    assign rho_cs  = fold_cs(rho_rot[CORDIC_STAGES]);
    assign th_cs   = fold_cs(th_rot[CORDIC_STAGES]);
    assign cos_rho = rho_cs[63:32];
    assign sin_rho = rho_cs[31:0];
    assign cos_th  = th_cs[63:32];
    assign sin_th  = th_cs[31:0];

    // multiply stage
    logic signed [63:0] prod_x_reg;
    logic signed [63:0] prod_z_reg;
    logic signed [31:0] sin_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_x_reg <= cos_rho * cos_th;
            prod_z_reg <= cos_rho * sin_th;
            sin_reg    <= sin_rho;
        end
    end

    // grid flags and triangle corners travel beside the arithmetic
    side_beat_t side_reg [0:SIDE_N-1];
    side_beat_t side_next;
    logic [9:0]  stride;
    logic [19:0] k1_full;

    always_comb begin
        stride          = {1'b0, sector_eff} + 10'd1;
        k1_full         = 20'(s_stack_index * stride) + {11'd0, s_sector_index};
        side_next.vld   = s_valid;
        side_next.pv    = (s_stack_index <= stack_eff) && (s_sector_index <= sector_eff);
        side_next.qv    = (s_stack_index < stack_eff) && (s_sector_index < sector_eff);
        side_next.k1    = k1_full[16:0];
        side_next.k2    = 17'(k1_full[16:0] + {7'd0, stride});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < SIDE_N; n++) begin
                side_reg[n].vld <= 1'b0;
            end
        end else if (adv) begin
            side_reg[0] <= side_next;
            for (int n = 1; n < SIDE_N; n++) begin
                side_reg[n] <= side_reg[n-1];
            end
        end
    end

    // rounding and saturation
    function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
        logic signed [15:0] r;
        r = v[15:0];
        if (v > 34'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -34'sd32768) begin
            r = -16'sh8000;
        end
        return r;
    endfunction

    logic signed [32:0] sin_rnd;
    logic signed [64:0] px_rnd;
    logic signed [64:0] pz_rnd;
    logic signed [33:0] py_q;
    logic signed [33:0] px_q;
    logic signed [33:0] pz_q;
    logic signed [32:0] sin_sh;
    logic signed [64:0] px_sh;
    logic signed [64:0] pz_sh;

    always_comb begin
        sin_rnd = 33'(sin_reg) + 33'sd16384;
        px_rnd  = 65'(prod_x_reg) + (65'sd1 <<< 44);
        pz_rnd  = 65'(prod_z_reg) + (65'sd1 <<< 44);
        sin_sh  = sin_rnd >>> 15;
        px_sh   = px_rnd >>> 45;
        pz_sh   = pz_rnd >>> 45;
        py_q    = 34'(sin_sh);
        px_q    = px_sh[33:0];
        pz_q    = pz_sh[33:0];
    end

    // output register
    side_beat_t         last;
    logic               point_valid_reg;
    logic signed [15:0] pos_x_reg;
    logic signed [15:0] pos_y_reg;
    logic signed [15:0] pos_z_reg;
    logic               quad_valid_reg;
    logic [16:0]        k1_reg;
    logic [16:0]        k2_reg;

    assign last = side_reg[SIDE_N-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= last.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            point_valid_reg <= last.pv;
            quad_valid_reg  <= last.qv;
            pos_x_reg       <= sat16(px_q);
            pos_y_reg       <= sat16(py_q);
            pos_z_reg       <= sat16(pz_q);
            k1_reg          <= last.qv ? last.k1 : 17'd0;
            k2_reg          <= last.qv ? last.k2 : 17'd0;
        end
    end

    logic [16:0] k1_inc;
    logic [16:0] k2_inc;
    assign k1_inc = quad_valid_reg ? 17'(k1_reg + 17'd1) : 17'd0;
    assign k2_inc = quad_valid_reg ? 17'(k2_reg + 17'd1) : 17'd0;

    assign m_valid       = m_valid_reg;
    assign m_point_valid = point_valid_reg;
    assign m_pos_x       = pos_x_reg;
    assign m_pos_y       = pos_y_reg;
    assign m_pos_z       = pos_z_reg;
    assign m_quad_valid  = quad_valid_reg;
    assign m_tri_a0      = k1_reg;
    assign m_tri_a1      = k2_reg;
    assign m_tri_a2      = k1_inc;
    assign m_tri_b0      = k1_inc;
    assign m_tri_b1      = k2_reg;
    assign m_tri_b2      = k2_inc;

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stand-alone check of the uv-sphere point generator. A directed table walks
// the grid corners, both poles and indices outside the grid; the extreme
// division counts follow, then random grid points under several idling phases.
// Every result beat is compared with a behavioural cordic predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import usg_pkg::*;

    localparam int ADDR_STACKS  = 0;
    localparam int ADDR_SECTORS = 4;
    localparam int DRAIN_CYCLES = 120;
    localparam int WATCHDOG_MAX = 20000;

    typedef struct {
        logic               pv;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
        logic               qv;
        logic [16:0]        tri_idx [6];
    } vertex_t;

    typedef struct {
        logic [8:0] stk;
        logic [8:0] sec;
        logic       fixed;
        logic       pv;
        logic       qv;
        logic signed [15:0] py;
    } row_t;

    logic aclk;
    logic aresetn;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic s_valid, s_ready;
    logic [8:0] s_stack_index, s_sector_index;
    logic m_valid, m_ready;
    logic m_point_valid, m_quad_valid;
    logic signed [15:0] m_pos_x, m_pos_y, m_pos_z;
    logic [16:0] m_tri_a0, m_tri_a1, m_tri_a2, m_tri_b0, m_tri_b1, m_tri_b2;

    uv_sphere_point_generator dut (.*);

    logic [8:0] stacks_reg, sectors_reg;
    vertex_t    vertex_q [$];
    int         n_errors;
    int         idle_cycles;
    int         send_pct, stall_pct;
    bit         hold_off;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [15:0] clamp_q15(longint v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    function automatic void sin_cos(input logic [31:0] ph, output longint c, output longint s);
        longint x, y, z, dx, dy;
        x = CORDIC_GAIN;
        y = 0;
        z = ph[29:0];
        for (int k = 0; k < CORDIC_STAGES_DEF; k++) begin
            dx = floor_shift(y, k);
            dy = floor_shift(x, k);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_turn(k));
            end else begin
                x += dx; y -= dy; z += longint'(atan_turn(k));
            end
        end
        case (ph[31:30])
            2'd0: begin c = x; s = y; end
            2'd1: begin c = -y; s = x; end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic longint eff_count(logic [8:0] r);
        if (r == 0) return 1;
        if (r > MAX_DIVISIONS_DEF) return MAX_DIVISIONS_DEF;
        return r;
    endfunction

    function automatic vertex_t sphere_vertex(logic [8:0] stk, logic [8:0] sec);
        vertex_t v;
        longint lc, sc, i, j, cr, sr, ct, st, k1, k2;
        logic [63:0] q;
        logic [31:0] rho, th;
        lc = eff_count(stacks_reg);
        sc = eff_count(sectors_reg);
        i = stk;
        j = sec;
        q = ((i << 32) + lc) / (2 * lc);
        rho = PHASE_QUARTER - q[31:0];
        q = ((j << 33) + sc) / (2 * sc);
        th = q[31:0];
        sin_cos(rho, cr, sr);
        sin_cos(th, ct, st);
        v.py = clamp_q15(floor_shift(sr + 16384, 15));
        v.px = clamp_q15(floor_shift(cr * ct + (64'sd1 <<< 44), 45));
        v.pz = clamp_q15(floor_shift(cr * st + (64'sd1 <<< 44), 45));
        v.pv = (i <= lc) && (j <= sc);
        v.qv = (i < lc) && (j < sc);
        k1 = i * (sc + 1) + j;
        k2 = k1 + sc + 1;
        v.tri_idx[0] = v.qv ? k1[16:0] : '0;
        v.tri_idx[1] = v.qv ? k2[16:0] : '0;
        v.tri_idx[2] = v.qv ? k1[16:0] + 17'd1 : '0;
        v.tri_idx[3] = v.tri_idx[2];
        v.tri_idx[4] = v.tri_idx[1];
        v.tri_idx[5] = v.qv ? k2[16:0] + 17'd1 : '0;
        return v;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        n_errors++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    task automatic apb_write(int addr, logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr[2:0]; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_STACKS) stacks_reg = val[8:0];
        else sectors_reg = val[8:0];
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (vertex_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_counts(logic [8:0] l, logic [8:0] s);
        wait_drained();
        apb_write(ADDR_STACKS, {23'd0, l});
        apb_write(ADDR_SECTORS, {23'd0, s});
    endtask

    // one beat on s_, prediction queued at the accepting edge
    task automatic send_point(logic [8:0] stk, logic [8:0] sec);
        while ($urandom_range(99) < send_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_stack_index <= stk;
        s_sector_index <= sec;
        do @(posedge aclk); while (!s_ready);
        vertex_q = {vertex_q, sphere_vertex(stk, sec)};
    endtask

    // receiver
    always @(posedge aclk) begin
        if (aresetn)
            m_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    // result checker
    always @(posedge aclk) begin
        vertex_t w;
        logic [16:0] got [6];
        if (aresetn && m_valid && m_ready) begin
            if (vertex_q.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                w = vertex_q.pop_front();
                got = '{m_tri_a0, m_tri_a1, m_tri_a2, m_tri_b0, m_tri_b1, m_tri_b2};
                if (m_point_valid !== w.pv) report_mismatch("point_valid", m_point_valid, w.pv);
                if (m_pos_x !== w.px) report_mismatch("pos_x", m_pos_x, w.px);
                if (m_pos_y !== w.py) report_mismatch("pos_y", m_pos_y, w.py);
                if (m_pos_z !== w.pz) report_mismatch("pos_z", m_pos_z, w.pz);
                if (m_quad_valid !== w.qv) report_mismatch("quad_valid", m_quad_valid, w.qv);
                for (int k = 0; k < 6; k++)
                    if (got[k] !== w.tri_idx[k]) report_mismatch("tri index", got[k], w.tri_idx[k]);
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_MAX) begin
                $display("uv_sphere_point_generator verification failed");
                $finish;
            end
        end
    end

    row_t rows [$];

    initial begin
        vertex_t v;
        n_errors = 0; idle_cycles = 0; send_pct = 0; stall_pct = 0; hold_off = 0;
        aresetn = 1'b0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        s_valid = 0; s_stack_index = 0; s_sector_index = 0; m_ready = 0;
        stacks_reg = 9'd16; sectors_reg = 9'd32;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset counts, poles, corners, outside grid, full-scale index
        rows = '{
            '{9'd0,   9'd0,   1, 1, 1, 16'sd32767},
            '{9'd16,  9'd0,   1, 1, 0, -16'sd32768},
            '{9'd8,   9'd8,   0, 1, 1, 16'sd0},
            '{9'd15,  9'd31,  0, 1, 1, 16'sd0},
            '{9'd16,  9'd32,  0, 1, 0, 16'sd0},
            '{9'd17,  9'd0,   0, 0, 0, 16'sd0},
            '{9'd0,   9'd33,  0, 0, 0, 16'sd0},
            '{9'd511, 9'd511, 0, 0, 0, 16'sd0},
            '{9'h155, 9'h0aa, 0, 0, 0, 16'sd0},
            '{9'h0aa, 9'h155, 0, 0, 0, 16'sd0}
        };
        foreach (rows[r]) begin
            v = sphere_vertex(rows[r].stk, rows[r].sec);
            if (v.pv !== rows[r].pv || v.qv !== rows[r].qv ||
                (rows[r].fixed && v.py !== rows[r].py))
                report_mismatch("table row", r, -1);
            send_point(rows[r].stk, rows[r].sec);
        end

        // zero counts act as one, oversize as the limit
        set_counts(9'd0, 9'd0);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) send_point(9'(i), 9'(j));
        set_counts(9'd511, 9'd256);
        send_point(9'd255, 9'd255);
        send_point(9'd256, 9'd256);
        send_point(9'd257, 9'd0);
        send_point(9'd128, 9'd64);

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_pct = 0;  stall_pct = 0;  set_counts(9'd16, 9'd32); end
                1: begin send_pct = 56; stall_pct = 0;  set_counts(9'd1, 9'd256); end
                2: begin send_pct = 0;  stall_pct = 56; set_counts(9'd256, 9'd1); end
                3: begin
                    send_pct = 37; stall_pct = 37;
                    set_counts(9'($urandom_range(511)), 9'($urandom_range(511)));
                end
                default: begin send_pct = 0; stall_pct = 0; set_counts(9'd7, 9'd13); end
            endcase
            if (ph == 4) begin
                // long receiver hold-off so the pipeline backs up into s_
                fork
                    begin hold_off = 1; repeat (300) @(posedge aclk); hold_off = 0; end
                join_none
            end
            for (int n = 0; n < 90; n++) begin
                if ($urandom_range(3) == 0)
                    send_point(9'($urandom_range(511)), 9'($urandom_range(511)));
                else
                    send_point(9'($urandom_range(32'(eff_count(stacks_reg) + 1))),
                               9'($urandom_range(32'(eff_count(sectors_reg) + 1))));
                if (n == 45) wait_drained();
            end
        end

        send_pct = 0; stall_pct = 0;
        wait_drained();
        if (n_errors == 0) begin
            $display("uv_sphere_point_generator verification clean");
        end else begin
            $display("uv_sphere_point_generator verification failed");
        end
        $finish;
    end
endmodule
